/* design/msp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

   localparam int MSP_NUM_MOTORS = 4;

   // field widths
   localparam int ID_W    = 2;
   localparam int TGT_W   = 8;
   localparam int PER_W   = 16;
   localparam int GAIN_W  = 8;
   localparam int SPEED_W = 14;
   localparam int CSR_IDX_W = 2;

   // datapath widths
   localparam int ERR_W     = 15;
   localparam int INTEG_W   = 24;
   localparam int DERIV_W   = 16;
   localparam int MUL_A_W   = INTEG_W + 1;
   localparam int PROD_W    = MUL_A_W + GAIN_W + 1;
   localparam int ACC_W     = PROD_W;
   localparam int DIV_W     = 16;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);
   localparam int CORR_W    = 11;
   localparam int RECIP_W   = 13;

   localparam logic [DIV_W-1:0] SPEED_NUM    = DIV_W'(10000);
   // divide by 100 as (x * 5243) >> 19, exact for every x below 43699
   localparam logic [RECIP_W-1:0] CORR_RECIP = RECIP_W'(5243);
   localparam int                 CORR_SHIFT = 19;
   // any magnitude at or above this drives the result into the clamp
   localparam logic [DIV_W-1:0] CORR_CAP     = DIV_W'(51200);

   localparam logic [INTEG_W-1:0] INTEG_MAX = {1'b0, {(INTEG_W-1){1'b1}}};
   localparam logic [INTEG_W-1:0] INTEG_MIN = {1'b1, {(INTEG_W-1){1'b0}}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN  = 2'd0,
      CSR_INTEG_GAIN = 2'd1,
      CSR_DERIV_GAIN = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      SEL_PROP,
      SEL_INTEG,
      SEL_DERIV
   } mul_sel_type;

   typedef struct packed {
      logic        load;
      logic        speed;
      logic        update;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        acc_clr;
      logic        acc_add;
      logic        scale;
      logic        out_load;
   } msp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } msp_stat_type;

endpackage

`default_nettype wire

/* design/msp_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface msp_req_if import msp_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ID_W-1:0]  motor_id;
   logic [TGT_W-1:0] target_speed;
   logic [PER_W-1:0] period_count;
   logic             reverse_bit;

   modport source (output valid, motor_id, target_speed, period_count, reverse_bit,
                   input ready);
   modport sink   (input valid, motor_id, target_speed, period_count, reverse_bit,
                   output ready);
endinterface

interface msp_rsp_if import msp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ID_W-1:0]    motor_out;
   logic [TGT_W-1:0]   drive_level;
   logic               drive_clamped;
   logic               direction;
   logic [SPEED_W-1:0] measured_speed;

   modport source (output valid, motor_out, drive_level, drive_clamped, direction,
                   measured_speed, input ready);
   modport sink   (input valid, motor_out, drive_level, drive_clamped, direction,
                   measured_speed, output ready);
endinterface

interface msp_csr_if import msp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [GAIN_W-1:0]    wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

/* design/msp_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module msp_div import msp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             load,
   input  wire logic [DIV_W-1:0] dividend,
   input  wire logic [DIV_W-1:0] divisor,
   output logic      [DIV_W-1:0] quotient,
   output logic                  busy
);

   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     rem_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     dsr_ff;
   logic [DIV_W:0]       shifted;
   logic [DIV_W:0]       diff;
   logic                 fits;

   assign busy     = (cnt_ff != '0);
   assign quotient = quo_ff;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      fits    = (shifted >= {1'b0, dsr_ff});
      diff    = shifted - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (load) begin
         cnt_ff <= DIV_CNT_W'(DIV_W);
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         dsr_ff <= divisor;
      end else if (busy) begin
         rem_ff <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
         quo_ff <= {quo_ff[DIV_W-2:0], fits};
      end
   end

endmodule

`default_nettype wire

/* design/msp_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module msp_ctrl import msp_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   input  wire msp_stat_type stat,
   output msp_cmd_type       cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SPEED,
      ST_UPDATE,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_SCALE,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '{load: 1'b0, speed: 1'b0, update: 1'b0, mul_en: 1'b0, mul_sel: SEL_PROP,
              acc_clr: 1'b0, acc_add: 1'b0, scale: 1'b0, out_load: 1'b0};
      unique case (state_ff)
         ST_IDLE:   cmd.load   = req_valid;
         ST_SPEED:  cmd.speed  = !stat.div_busy;
         ST_UPDATE: cmd.update = 1'b1;
         ST_MUL_P: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_PROP;
            cmd.acc_clr = 1'b1;
         end
         ST_MUL_I: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_INTEG;
            cmd.acc_add = 1'b1;
         end
         ST_MUL_D: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = SEL_DERIV;
            cmd.acc_add = 1'b1;
         end
         ST_ACC:    cmd.acc_add = 1'b1;
         ST_SCALE:  cmd.scale   = 1'b1;
         // load the output register only once it is free or being drained
         ST_FINISH: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE:   if (req_valid) state_ff <= ST_SPEED;
            ST_SPEED:  if (!stat.div_busy) state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= ST_MUL_P;
            ST_MUL_P:  state_ff <= ST_MUL_I;
            ST_MUL_I:  state_ff <= ST_MUL_D;
            ST_MUL_D:  state_ff <= ST_ACC;
            ST_ACC:    state_ff <= ST_SCALE;
            ST_SCALE:  state_ff <= ST_FINISH;
            ST_FINISH: if (cmd.out_load) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

/* design/msp_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none

module msp_dpath import msp_pkg::*; #(
   parameter int NUM_MOTORS = MSP_NUM_MOTORS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire msp_cmd_type          cmd,
   output msp_stat_type              stat,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [GAIN_W-1:0]    csr_wdata,
   input  wire logic [ID_W-1:0]      req_motor_id,
   input  wire logic [TGT_W-1:0]     req_target_speed,
   input  wire logic [PER_W-1:0]     req_period_count,
   input  wire logic                 req_reverse_bit,
   output logic      [ID_W-1:0]      rsp_motor_out,
   output logic      [TGT_W-1:0]     rsp_drive_level,
   output logic                      rsp_drive_clamped,
   output logic                      rsp_direction,
   output logic      [SPEED_W-1:0]   rsp_measured_speed
);

   localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

   logic [GAIN_W-1:0] pgain_ff, igain_ff, dgain_ff;

   logic [ID_W-1:0]  ch_ff;
   logic [TGT_W-1:0] tgt_ff;
   logic             rev_ff;

   logic signed [INTEG_W-1:0] integ_mem_ff [NUM_MOTORS];
   logic signed [ERR_W-1:0]   prev_mem_ff  [NUM_MOTORS];

   logic [SPEED_W-1:0]        speed_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [DERIV_W-1:0] deriv_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic                      neg_ff;
   logic [CORR_W-2:0]         corr_q_ff;

   logic [ID_W-1:0]    out_motor_ff;
   logic [TGT_W-1:0]   out_drive_ff;
   logic               out_clamp_ff;
   logic               out_dir_ff;
   logic [SPEED_W-1:0] out_speed_ff;

   logic             div_load;
   logic [DIV_W-1:0] div_dividend;
   logic [DIV_W-1:0] div_divisor;
   logic [DIV_W-1:0] div_quo;
   logic             div_busy;

   logic [ERR_W-1:0]    err_in;
   logic                ch_valid;
   logic [IDX_W-1:0]    idx;
   logic [INTEG_W-1:0]  integ_old;
   logic [ERR_W-1:0]    prev_old;
   logic [INTEG_W:0]    isum;
   logic [INTEG_W-1:0]  integ_sat;
   logic [DERIV_W-1:0]  deriv_in;
   logic                tgt_zero;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [GAIN_W:0]    mul_b;
   logic signed [PROD_W-1:0]  mul_full;

   logic [ACC_W-1:0]         acc_mag;
   logic [DIV_W-1:0]         scale_val;
   logic [DIV_W+RECIP_W-1:0] recip_prod;
   logic [CORR_W-2:0]        corr_mag;
   logic [CORR_W-1:0]        corr;
   logic [CORR_W-1:0]        dsum;
   logic [TGT_W-1:0]         drive_in;
   logic                     clamp_in;

   assign stat.div_busy = div_busy;

   msp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .load     (div_load),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .quotient (div_quo),
      .busy     (div_busy)
   );

   // the divider works out the speed; a zero period counts as one
   always_comb begin
      div_load     = cmd.load;
      div_dividend = SPEED_NUM;
      div_divisor  = (req_period_count == '0) ? DIV_W'(1) : req_period_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pgain_ff <= '0;
         igain_ff <= '0;
         dgain_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_index))
            CSR_PROP_GAIN:  pgain_ff <= csr_wdata;
            CSR_INTEG_GAIN: igain_ff <= csr_wdata;
            CSR_DERIV_GAIN: dgain_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      err_in    = {{(ERR_W-TGT_W){1'b0}}, tgt_ff} - {1'b0, div_quo[SPEED_W-1:0]};
      ch_valid  = (int'(ch_ff) < NUM_MOTORS);
      idx       = IDX_W'(ch_ff);
      integ_old = ch_valid ? integ_mem_ff[idx] : '0;
      prev_old  = ch_valid ? prev_mem_ff[idx] : '0;
      isum      = {integ_old[INTEG_W-1], integ_old}
                + {{(INTEG_W+1-ERR_W){err_ff[ERR_W-1]}}, err_ff};
      // saturate on signed overflow of the running sum
      if (isum[INTEG_W] != isum[INTEG_W-1]) begin
         integ_sat = isum[INTEG_W] ? INTEG_MIN : INTEG_MAX;
      end else begin
         integ_sat = isum[INTEG_W-1:0];
      end
      deriv_in = {err_ff[ERR_W-1], err_ff} - {prev_old[ERR_W-1], prev_old};
      tgt_zero = (tgt_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_MOTORS; k++) begin
            integ_mem_ff[k] <= '0;
            prev_mem_ff[k]  <= '0;
         end
      end else if (cmd.update && ch_valid) begin
         integ_mem_ff[idx] <= tgt_zero ? '0 : integ_sat;
         prev_mem_ff[idx]  <= err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff  <= req_motor_id;
         tgt_ff <= req_target_speed;
         rev_ff <= req_reverse_bit;
      end
      if (cmd.speed) begin
         speed_ff <= div_quo[SPEED_W-1:0];
         err_ff   <= err_in;
      end
      if (cmd.update) begin
         err_ff   <= tgt_zero ? '0 : err_ff;
         integ_ff <= tgt_zero ? '0 : integ_sat;
         deriv_ff <= tgt_zero ? '0 : deriv_in;
      end
   end

   // one shared multiplier takes the three terms in turn
   always_comb begin
      unique case (cmd.mul_sel)
         SEL_PROP: begin
            mul_a = {{(MUL_A_W-ERR_W){err_ff[ERR_W-1]}}, err_ff};
            mul_b = {1'b0, pgain_ff};
         end
         SEL_INTEG: begin
            mul_a = {integ_ff[INTEG_W-1], integ_ff};
            mul_b = {1'b0, igain_ff};
         end
         SEL_DERIV: begin
            mul_a = {{(MUL_A_W-DERIV_W){deriv_ff[DERIV_W-1]}}, deriv_ff};
            mul_b = {1'b0, dgain_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_full = mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_full;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (cmd.acc_add) begin
         acc_ff <= acc_ff + prod_ff;
      end
      if (cmd.scale) begin
         neg_ff    <= acc_ff[ACC_W-1];
         corr_q_ff <= recip_prod[CORR_SHIFT +: CORR_W-1];
      end
   end

   // divide the magnitude so the quotient truncates toward zero
   always_comb begin
      acc_mag    = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
      scale_val  = (acc_mag >= ACC_W'(CORR_CAP)) ? CORR_CAP : acc_mag[DIV_W-1:0];
      recip_prod = {{RECIP_W{1'b0}}, scale_val} * {{DIV_W{1'b0}}, CORR_RECIP};
      corr_mag   = corr_q_ff;
      corr       = neg_ff ? (~{1'b0, corr_mag} + 1'b1) : {1'b0, corr_mag};
      dsum       = {{(CORR_W-TGT_W){1'b0}}, tgt_ff} + corr;
      if (dsum[CORR_W-1]) begin
         drive_in = '0;
         clamp_in = 1'b1;
      end else if (dsum[CORR_W-2:TGT_W] != '0) begin
         drive_in = '1;
         clamp_in = 1'b1;
      end else begin
         drive_in = dsum[TGT_W-1:0];
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_motor_ff <= ch_ff;
         out_drive_ff <= drive_in;
         out_clamp_ff <= clamp_in;
         out_dir_ff   <= ~rev_ff;
         out_speed_ff <= speed_ff;
      end
   end

   assign rsp_motor_out      = out_motor_ff;
   assign rsp_drive_level    = out_drive_ff;
   assign rsp_drive_clamped  = out_clamp_ff;
   assign rsp_direction      = out_dir_ff;
   assign rsp_measured_speed = out_speed_ff;

endmodule

`default_nettype wire

/* design/motor_speed_pid.sv */
// A request is taken only in the idle state, so the next one waits until the last response
// is loaded; the 16-step restoring divider gives the speed, then eight sequencer steps
// update the state, multiply and scale by a reciprocal.
// A finished response waits in the output register while the next request is taken.
// Reset (synchronous, active high) clears the gains and the per-motor integral and
// previous-error registers, and empties the output register.
`timescale 1ns / 1ps
`default_nettype none

module motor_speed_pid import msp_pkg::*; #(
   parameter int NUM_MOTORS = MSP_NUM_MOTORS
) (
   input  wire logic  clock,
   input  wire logic  reset,
   msp_req_if.sink    req_bus,
   msp_rsp_if.source  rsp_bus,
   msp_csr_if.sink    csr_bus
);

   msp_cmd_type  cmd;
   msp_stat_type stat;
   logic         req_ready;
   logic         rsp_valid;

   assign csr_bus.ready = 1'b1;
   assign req_bus.ready = req_ready;
   assign rsp_bus.valid = rsp_valid;

   msp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   msp_dpath #(
      .NUM_MOTORS (NUM_MOTORS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .csr_we             (csr_bus.valid),
      .csr_index          (csr_bus.index),
      .csr_wdata          (csr_bus.wdata),
      .req_motor_id       (req_bus.motor_id),
      .req_target_speed   (req_bus.target_speed),
      .req_period_count   (req_bus.period_count),
      .req_reverse_bit    (req_bus.reverse_bit),
      .rsp_motor_out      (rsp_bus.motor_out),
      .rsp_drive_level    (rsp_bus.drive_level),
      .rsp_drive_clamped  (rsp_bus.drive_clamped),
      .rsp_direction      (rsp_bus.direction),
      .rsp_measured_speed (rsp_bus.measured_speed)
   );

   // never overwrite a response beat that has not been taken
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || rsp_bus.ready))
      else $error("output register overwritten while holding a beat");

   // no new request beat straight after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_ready) |=> !req_ready)
      else $error("request taken while a tick is in progress");

   // the divider is only reloaded when idle
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !stat.div_busy)
      else $error("divider reloaded while busy");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_load))
      else $error("response valid without a result load");

endmodule

`default_nettype wire

/* bench/motor_speed_pid_tb.sv */
`timescale 1ns / 1ps

module motor_speed_pid_tb;
   import msp_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;
   localparam longint INTEG_TOP = (longint'(1) <<< (INTEG_W - 1)) - 1;
   localparam longint INTEG_BOT = -(longint'(1) <<< (INTEG_W - 1));

   typedef struct packed {
      logic [ID_W-1:0]  motor_id;
      logic [TGT_W-1:0] target;
      logic [PER_W-1:0] period;
      logic             reverse_bit;
   } tick_type;

   typedef struct packed {
      logic [ID_W-1:0]    motor;
      logic [TGT_W-1:0]   level;
      logic               clamped;
      logic               dir;
      logic [SPEED_W-1:0] speed;
   } drive_type;

   class drive_scoreboard;
      logic [GAIN_W-1:0]         gain_p, gain_i, gain_d;
      logic signed [INTEG_W-1:0] integral [MSP_NUM_MOTORS];
      logic signed [ERR_W-1:0]   prev_err [MSP_NUM_MOTORS];
      drive_type                 expected_drive [$];
      int                        failures;

      function new();
         gain_p = '0;
         gain_i = '0;
         gain_d = '0;
         failures = 0;
         foreach (integral[k]) begin
            integral[k] = '0;
            prev_err[k] = '0;
         end
      endfunction

      function void set_gain(logic [CSR_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
         case (idx)
            CSR_PROP_GAIN:  gain_p = val;
            CSR_INTEG_GAIN: gain_i = val;
            CSR_DERIV_GAIN: gain_d = val;
            default: ;
         endcase
      endfunction

      // predict the drive beat of one accepted tick and advance the channel state
      function void note_tick(tick_type t);
         int unsigned per;
         int          spd, err, prev, deriv;
         longint      integ, total, corr, level;
         bit          in_range;
         drive_type   res;
         in_range = int'(t.motor_id) < MSP_NUM_MOTORS;
         per = (t.period == '0) ? 1 : int'(t.period);
         spd = 10000 / per;
         err = int'(t.target) - spd;
         integ = in_range ? longint'(integral[t.motor_id]) : 0;
         prev = in_range ? int'(prev_err[t.motor_id]) : 0;
         integ += err;
         if (integ > INTEG_TOP) integ = INTEG_TOP;
         if (integ < INTEG_BOT) integ = INTEG_BOT;
         deriv = err - prev;
         // the raw error is kept even when the target is zero
         if (in_range) prev_err[t.motor_id] = ERR_W'(err);
         if (t.target == '0) begin
            err = 0;
            integ = 0;
            deriv = 0;
         end
         if (in_range) integral[t.motor_id] = INTEG_W'(integ);
         total = longint'(gain_p) * err + longint'(gain_i) * integ
               + longint'(gain_d) * deriv;
         corr = total / 100;
         level = longint'(t.target) + corr;
         res.motor = t.motor_id;
         res.clamped = 1'b0;
         if (level < 0) begin
            res.level = '0;
            res.clamped = 1'b1;
         end else if (level > 255) begin
            res.level = '1;
            res.clamped = 1'b1;
         end else begin
            res.level = TGT_W'(level);
         end
         res.dir = ~t.reverse_bit;
         res.speed = SPEED_W'(spd);
         expected_drive.push_back(res);
      endfunction

      function void check_drive(drive_type got);
         drive_type want;
         if (expected_drive.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("[%0t] drive beat with nothing pending: motor %0d level %0d",
                        $time, got.motor, got.level);
            return;
         end
         want = expected_drive.pop_front();
         if (got.motor !== want.motor || got.level !== want.level ||
             got.clamped !== want.clamped || got.dir !== want.dir ||
             got.speed !== want.speed) begin
            failures++;
            if (failures <= 10)
               $display({"[%0t] drive mismatch: motor %0d/%0d level %0d/%0d ",
                         "clamped %0b/%0b dir %0b/%0b speed %0d/%0d (exp/got)"},
                        $time, want.motor, got.motor, want.level, got.level,
                        want.clamped, got.clamped, want.dir, got.dir,
                        want.speed, got.speed);
         end
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   msp_req_if req_if ();
   msp_rsp_if rsp_if ();
   msp_csr_if csr_if ();

   drive_scoreboard board;

   motor_speed_pid dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         board.check_drive(drive_type'{rsp_if.motor_out, rsp_if.drive_level,
                                       rsp_if.drive_clamped, rsp_if.direction,
                                       rsp_if.measured_speed});
   end

   // receiver stalls: drive ready from a 16-bit pattern that is swapped for a new random one
   initial begin
      logic [15:0] ready_mask;
      int unsigned step;
      ready_mask = 16'hFFFF;
      step = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (step % 256 == 0) begin
            case ($urandom_range(3))
               0: ready_mask = 16'hFFFF;
               1: ready_mask = 16'h0001 << $urandom_range(15);
               default: ready_mask = 16'($urandom) | 16'h0001;
            endcase
         end
         rsp_if.ready <= ready_mask[step % 16];
         step++;
      end
   end

   initial begin
      #(20_000_000);
      $display("motor_speed_pid verification failed");
      $finish;
   end

   function automatic tick_type make_tick(logic [ID_W-1:0] id, logic [TGT_W-1:0] tgt,
                                          logic [PER_W-1:0] per, logic rev);
      tick_type t;
      t.motor_id = id;
      t.target = tgt;
      t.period = per;
      t.reverse_bit = rev;
      return t;
   endfunction

   function automatic tick_type random_tick(bit windup, logic [ID_W-1:0] wind_motor);
      tick_type    t;
      int unsigned pick;
      int unsigned near;
      t.reverse_bit = 1'($urandom);
      if (windup) begin
         // large negative error on one channel to drive its integral into saturation
         t.motor_id = wind_motor;
         t.target = TGT_W'($urandom_range(255, 1));
         t.period = PER_W'($urandom_range(1));
         return t;
      end
      t.motor_id = ID_W'($urandom_range(MSP_NUM_MOTORS - 1));
      pick = $urandom_range(15);
      t.target = (pick == 0) ? '0 : (pick == 1) ? '1 : TGT_W'($urandom_range(255, 1));
      pick = $urandom_range(15);
      case (pick)
         0: t.period = '0;
         1: t.period = '1;
         2: t.period = PER_W'($urandom_range(3, 1));
         3, 4: t.period = PER_W'($urandom);
         default: begin
            // track the target: speed within a few counts of it
            near = int'(t.target) + $urandom_range(40);
            near = (near > 20) ? near - 20 : 1;
            t.period = PER_W'(10000 / near);
         end
      endcase
      return t;
   endfunction

   task automatic send_tick(input tick_type t);
      req_if.valid <= 1'b1;
      req_if.motor_id <= t.motor_id;
      req_if.target_speed <= t.target;
      req_if.period_count <= t.period;
      req_if.reverse_bit <= t.reverse_bit;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      board.note_tick(t);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= val;
      @(posedge clock);
      while (csr_if.ready !== 1'b1) @(posedge clock);
      board.set_gain(idx, val);
   endtask

   task automatic write_gains(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                              input logic [GAIN_W-1:0] d);
      csr_write(CSR_PROP_GAIN, p);
      csr_write(CSR_SPARE, GAIN_W'($urandom));
      csr_write(CSR_INTEG_GAIN, i);
      csr_write(CSR_DERIV_GAIN, d);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (board.pending() != 0) @(posedge clock);
   endtask

   task automatic drive_phase(input int count, input bit windup,
                              input logic [ID_W-1:0] wind_motor);
      int sent, burst, gap, k;
      sent = 0;
      while (sent < count) begin
         burst = ($urandom_range(4) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
         gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(60, 1);
         for (k = 0; k < burst && sent < count; k++) begin
            send_tick(random_tick(windup, wind_motor));
            sent++;
         end
         // hold valid across a zero gap so it is never dropped and raised in one step
         if (gap > 0 || sent >= count) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   initial begin
      int phase;
      logic [GAIN_W-1:0] gp, gi, gd;
      board = new();
      req_if.valid <= 1'b0;
      req_if.motor_id <= '0;
      req_if.target_speed <= '0;
      req_if.period_count <= '0;
      req_if.reverse_bit <= 1'b0;
      csr_if.valid <= 1'b0;
      csr_if.index <= CSR_PROP_GAIN;
      csr_if.wdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      write_gains(8'd40, 8'd5, 8'd30);
      send_tick(make_tick(2'd0, 8'd0, 16'd0, 1'b0));
      send_tick(make_tick(2'd1, 8'd255, 16'hFFFF, 1'b1));
      send_tick(make_tick(2'd2, 8'd255, 16'd1, 1'b0));
      send_tick(make_tick(2'd3, 8'd100, 16'd100, 1'b1));
      send_tick(make_tick(2'd0, 8'd1, 16'd40, 1'b0));
      send_tick(make_tick(2'd0, 8'd200, 16'd50, 1'b1));
      send_tick(make_tick(2'd0, 8'd0, 16'd10000, 1'b0));
      send_tick(make_tick(2'd0, 8'd128, 16'd100, 1'b1));
      send_tick(make_tick(2'd1, 8'd128, 16'h8000, 1'b0));
      send_tick(make_tick(2'd1, 8'd128, 16'h7FFF, 1'b1));
      send_tick(make_tick(2'd1, 8'd128, 16'hAAAA, 1'b0));
      send_tick(make_tick(2'd1, 8'd128, 16'h5555, 1'b1));
      send_tick(make_tick(2'd2, 8'hAA, 16'd59, 1'b0));
      send_tick(make_tick(2'd2, 8'h55, 16'd117, 1'b1));
      send_tick(make_tick(2'd3, 8'd50, 16'd10001, 1'b0));
      send_tick(make_tick(2'd3, 8'd50, 16'd9999, 1'b1));
      send_tick(make_tick(2'd3, 8'd50, 16'd2, 1'b0));
      send_tick(make_tick(2'd3, 8'd0, 16'd0, 1'b1));
      send_tick(make_tick(2'd2, 8'd1, 16'hFFFF, 1'b0));
      req_if.valid <= 1'b0;
      wait_drained();

      for (phase = 0; phase < 11; phase++) begin
         case (phase)
            0: begin gp = 8'd0;   gi = 8'd0;   gd = 8'd0;   end
            1: begin gp = 8'd255; gi = 8'd255; gd = 8'd255; end
            2: begin gp = 8'd255; gi = 8'd0;   gd = 8'd0;   end
            3: begin gp = 8'd0;   gi = 8'd255; gd = 8'd0;   end
            4: begin gp = 8'd0;   gi = 8'd0;   gd = 8'd255; end
            9: begin
               gp = GAIN_W'($urandom);
               gi = GAIN_W'($urandom_range(255, 1));
               gd = GAIN_W'($urandom);
            end
            default: begin
               gp = GAIN_W'($urandom);
               gi = GAIN_W'($urandom);
               gd = GAIN_W'($urandom);
            end
         endcase
         write_gains(gp, gi, gd);
         if (phase == 9)
            drive_phase(900, 1'b1, ID_W'($urandom_range(MSP_NUM_MOTORS - 1)));
         else
            drive_phase(100, 1'b0, '0);
         wait_drained();
      end

      repeat (60) @(posedge clock);
      if (board.failures == 0 && board.pending() == 0)
         $display("motor_speed_pid verification clean");
      else
         $display("motor_speed_pid verification failed");
      $finish;
   end

endmodule
